// ===== design/sidg_pkg.sv =====
// Shared types and constants for the sequence id graph checker.
package sidg_pkg;

    localparam int ID_W     = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int APOS_W   = 7;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_NODES   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ODD_NODE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVEN_EDGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_GAP        = 3'd5;
    localparam logic [STATUS_W-1:0] ST_HORIZON    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_CAPACITY   = 3'd7;

    localparam logic [APOS_W-1:0] APOS_SAT = 7'd127;
    localparam logic [POS_W-1:0]  POS_SAT  = 6'd63;

    // Control broadcast to every cell of the id chain.
    typedef struct packed {
        logic shift;   // take the neighbor's id
        logic sample;  // register the compare against the key
    } cell_ctl_t;

endpackage

// ===== design/sequence_id_graph_checker.sv =====
// Top level of the sequence id graph checker: control, range tracking, id chain.
//
// Elements of one order arrive on the s_ stream, nodes first and then edges.
// s_tdata carries sequence_id and released, s_tuser the element kind and the
// no-element flag, s_tlast ends the order. The beat with s_tlast set yields
// one result beat on the m_ stream; other beats yield none.
// Stored ids sit in a chain of MAX_ELEMENTS cells; a new id enters the first
// cell and every cell hands its id to the next one.
// Steps: a beat carrying an element is accepted with the per-cell compare and,
// while no error is latched, then evaluated from the registered match bits in
// S_EVAL; a beat without an element, or any beat once an error is latched,
// skips that step. The last beat then passes through S_FIN to form the result,
// and m_tvalid rises together with s_tready.
// After the result is loaded the block clears its counters and flags and
// starts a new order. Reset does the same; the chain contents are not
// cleared, only the fill count that marks which cells are live.
// While the result register is full and m_tready is low, a newly finished
// order waits in S_FIN and the block accepts no beat until the result is taken.
module sequence_id_graph_checker #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] sequence_id, [32] released, zero pad
    input  logic [1:0]  s_tuser,   // [0] element_is_edge, [1] no_element
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [2:0] status, [34:3] offending_sequence_id,
                                   // [35] offending_is_edge,
                                   // [41:36] offending_position, zero pad
);

    localparam int ID_W     = sidg_pkg::ID_W;
    localparam int STATUS_W = sidg_pkg::STATUS_W;
    localparam int POS_W    = sidg_pkg::POS_W;
    localparam int APOS_W   = sidg_pkg::APOS_W;
    localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);

    localparam logic [1:0] S_IN   = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]          state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [APOS_W-1:0]   apos_reg;
    logic [POS_W-1:0]    elem_pos_reg;
    logic [ID_W-1:0]     lo_reg;
    logic [ID_W-1:0]     hi_reg;
    logic [ID_W-1:0]     hbase_reg;
    logic [ID_W-1:0]     lhor_reg;
    logic                seen_node_reg;
    logic                seen_base_reg;
    logic                seen_hor_reg;
    logic [STATUS_W-1:0] ferr_reg;
    logic [ID_W-1:0]     err_id_reg;
    logic                err_edge_reg;
    logic [POS_W-1:0]    err_pos_reg;

    logic [ID_W-1:0]     key_reg;
    logic                key_edge_reg;
    logic                key_rel_reg;
    logic                key_last_reg;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic                out_edge_reg;
    logic [POS_W-1:0]    out_pos_reg;

    logic                 accept;
    logic                 in_edge;
    logic                 in_none;
    logic [ID_W-1:0]      in_id;
    logic                 in_rel;
    logic                 dup;
    logic                 store;
    logic                 fin_go;
    logic [ID_W:0]        span;
    sidg_pkg::cell_ctl_t  ctl;
    logic [ID_W-1:0]      chain [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] match_vec;

    assign in_id   = s_tdata[ID_W-1:0];
    assign in_rel  = s_tdata[ID_W];
    assign in_edge = s_tuser[0];
    assign in_none = s_tuser[1];

    assign s_tready = (state_reg == S_IN);
    assign accept   = s_tvalid && s_tready;

    assign dup = |match_vec;

    // Store the element when it passes parity, duplicate and capacity checks.
    assign store = (state_reg == S_EVAL) && (ferr_reg == sidg_pkg::ST_OK) &&
                   (key_edge_reg == key_reg[0]) && !dup &&
                   (count_reg != CNT_W'(MAX_ELEMENTS));

    assign ctl.shift  = store;
    assign ctl.sample = accept;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            logic [ID_W-1:0] id_in;
            if (gi == 0) begin : g_head
                assign id_in = key_reg;
            end else begin : g_body
                assign id_in = chain[gi-1];
            end
            sidg_cell u_cell (
                .aclk   (aclk),
                .ctl    (ctl),
                .live   (CNT_W'(gi) < count_reg),
                .id_in  (id_in),
                .key    (in_id),
                .id_out (chain[gi]),
                .match  (match_vec[gi])
            );
        end
    endgenerate

    assign span   = {1'b0, hi_reg} - {1'b0, lo_reg} + {{ID_W{1'b0}}, 1'b1};
    assign fin_go = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg      <= in_id;
            key_edge_reg <= in_edge;
            key_rel_reg  <= in_rel;
            key_last_reg <= s_tlast;
            elem_pos_reg <= (apos_reg > APOS_W'(sidg_pkg::POS_SAT)) ?
                            sidg_pkg::POS_SAT : apos_reg[POS_W-1:0];
        end
        if (fin_go) begin
            if (!seen_node_reg) begin
                out_status_reg <= sidg_pkg::ST_NO_NODES;
            end else if (ferr_reg != sidg_pkg::ST_OK) begin
                out_status_reg <= ferr_reg;
            end else if (span != {{(ID_W + 1 - CNT_W){1'b0}}, count_reg}) begin
                out_status_reg <= sidg_pkg::ST_GAP;
            end else if (seen_base_reg && seen_hor_reg && (lhor_reg <= hbase_reg)) begin
                out_status_reg <= sidg_pkg::ST_HORIZON;
            end else begin
                out_status_reg <= sidg_pkg::ST_OK;
            end
            if (seen_node_reg && ferr_reg != sidg_pkg::ST_OK) begin
                out_id_reg   <= err_id_reg;
                out_edge_reg <= err_edge_reg;
                out_pos_reg  <= err_pos_reg;
            end else begin
                out_id_reg   <= '0;
                out_edge_reg <= 1'b0;
                out_pos_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IN;
            count_reg     <= '0;
            apos_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            hbase_reg     <= '0;
            lhor_reg      <= '1;
            seen_node_reg <= 1'b0;
            seen_base_reg <= 1'b0;
            seen_hor_reg  <= 1'b0;
            ferr_reg      <= sidg_pkg::ST_OK;
            err_id_reg    <= '0;
            err_edge_reg  <= 1'b0;
            err_pos_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !fin_go) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IN: begin
                    if (accept) begin
                        if (!in_none) begin
                            if (!in_edge) begin
                                seen_node_reg <= 1'b1;
                            end
                            if (apos_reg != sidg_pkg::APOS_SAT) begin
                                apos_reg <= apos_reg + APOS_W'(1);
                            end
                        end
                        if (!in_none && ferr_reg == sidg_pkg::ST_OK) begin
                            state_reg <= S_EVAL;
                        end else if (s_tlast) begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_EVAL: begin
                    if (ferr_reg == sidg_pkg::ST_OK) begin
                        if (store) begin
                            count_reg <= count_reg + CNT_W'(1);
                            if (count_reg == '0) begin
                                lo_reg <= key_reg;
                                hi_reg <= key_reg;
                            end else begin
                                if (key_reg < lo_reg) lo_reg <= key_reg;
                                if (key_reg > hi_reg) hi_reg <= key_reg;
                            end
                            if (key_rel_reg) begin
                                seen_base_reg <= 1'b1;
                                if (key_reg > hbase_reg) hbase_reg <= key_reg;
                            end else begin
                                seen_hor_reg <= 1'b1;
                                if (key_reg < lhor_reg) lhor_reg <= key_reg;
                            end
                        end else begin
                            // latch the first per-element error
                            err_id_reg   <= key_reg;
                            err_edge_reg <= key_edge_reg;
                            err_pos_reg  <= elem_pos_reg;
                            if (!key_edge_reg && key_reg[0]) begin
                                ferr_reg <= sidg_pkg::ST_ODD_NODE;
                            end else if (key_edge_reg && !key_reg[0]) begin
                                ferr_reg <= sidg_pkg::ST_EVEN_EDGE;
                            end else if (dup) begin
                                ferr_reg <= sidg_pkg::ST_DUPLICATE;
                            end else begin
                                ferr_reg <= sidg_pkg::ST_CAPACITY;
                            end
                        end
                    end
                    state_reg <= key_last_reg ? S_FIN : S_IN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        m_tvalid_reg  <= 1'b1;
                        count_reg     <= '0;
                        apos_reg      <= '0;
                        lo_reg        <= '0;
                        hi_reg        <= '0;
                        hbase_reg     <= '0;
                        lhor_reg      <= '1;
                        seen_node_reg <= 1'b0;
                        seen_base_reg <= 1'b0;
                        seen_hor_reg  <= 1'b0;
                        ferr_reg      <= sidg_pkg::ST_OK;
                        err_id_reg    <= '0;
                        err_edge_reg  <= 1'b0;
                        err_pos_reg   <= '0;
                        state_reg     <= S_IN;
                    end
                end
                default: begin
                    state_reg <= S_IN;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_pos_reg, out_edge_reg, out_id_reg, out_status_reg};

endmodule

// ===== design/sidg_cell.sv =====
// One cell of the id chain: holds one stored id and compares it to the key.
module sidg_cell (
    input  logic                      aclk,
    input  sidg_pkg::cell_ctl_t       ctl,
    input  logic                      live,
    input  logic [sidg_pkg::ID_W-1:0] id_in,
    input  logic [sidg_pkg::ID_W-1:0] key,
    output logic [sidg_pkg::ID_W-1:0] id_out,
    output logic                      match
);

    logic [sidg_pkg::ID_W-1:0] id_reg;
    logic                      match_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            id_reg <= id_in;
        end
        if (ctl.sample) begin
            match_reg <= live && (id_reg == key);
        end
    end

    assign id_out = id_reg;
    assign match  = match_reg;

endmodule
